// ----- sv/eno3_pkg.sv -----
// Shared constants, types and helper functions of the ENO3 advection stencil.
package eno3_pkg;

   // Stencil geometry: three cells on each side of the updated cell.
   localparam int STENCIL_HALF = 3;
   localparam int WIN_LEN      = 2 * STENCIL_HALF + 1;
   localparam int FILL_W       = $clog2(WIN_LEN + 1);

   // Field widths.
   localparam int SAMPLE_W = 32;
   localparam int CFL_W    = 32;

   // Widths of the finite differences and of the scaled sum.
   localparam int D1_W  = SAMPLE_W + 1;
   localparam int D2_W  = SAMPLE_W + 2;
   localparam int D3_W  = SAMPLE_W + 3;
   localparam int S6_W  = SAMPLE_W + 6;
   localparam int MAG_W = S6_W - 1;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CFL = CSR_IDX_W'(0);

   // Division by six through a reciprocal multiply on values below 2^23.
   localparam int DIV6_IN_W   = 23;
   localparam int DIV6_SHIFT  = DIV6_IN_W + 3;
   localparam int DIV6_MULT_W = DIV6_SHIFT - 2;
   localparam int DIV6_OUT_W  = DIV6_IN_W + DIV6_MULT_W - DIV6_SHIFT;
   localparam logic [DIV6_MULT_W-1:0] DIV6_MULT =
      DIV6_MULT_W'((1 << DIV6_SHIFT) / 6 + 1);

   // Seven samples, index WIN_LEN-1 holds the newest one.
   typedef logic [WIN_LEN-1:0][SAMPLE_W-1:0] win_type;

   // Selected differences of one cell, handed from selection to scaling.
   typedef struct packed {
      logic signed [D1_W-1:0]     d1;
      logic signed [D2_W-1:0]     c2;
      logic signed [D3_W-1:0]     c3;
      logic                       upwind_left;
      logic                       second_left;
      logic signed [SAMPLE_W-1:0] old;
      logic                       last;
   } sel_type;

   // Floor of v / 6; the rounding error of the reciprocal stays below 1/8.
   function automatic logic [DIV6_OUT_W-1:0] div6(input logic [DIV6_IN_W-1:0] v);
      logic [DIV6_IN_W+DIV6_MULT_W-1:0] prod;
      prod = (DIV6_IN_W + DIV6_MULT_W)'(v) * (DIV6_IN_W + DIV6_MULT_W)'(DIV6_MULT);
      return prod[DIV6_IN_W+DIV6_MULT_W-1:DIV6_SHIFT];
   endfunction

endpackage

// ----- sv/eno3_if.sv -----
// Request and result channel interfaces of the ENO3 advection stencil.
interface eno3_req_if;
   import eno3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       row_start;
   logic                       row_end;

   modport source (output valid, output sample, output row_start, output row_end,
                   input ready);
   modport sink (input valid, input sample, input row_start, input row_end,
                 output ready);
endinterface

interface eno3_rsp_if;
   import eno3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] new_value;
   logic                       last_of_row;

   modport source (output valid, output new_value, output last_of_row, input ready);
   modport sink (input valid, input new_value, input last_of_row, output ready);
endinterface

// ----- sv/eno3_window.sv -----
// Sample window and row fill tracking of the ENO3 advection stencil.
module eno3_window (
   input  logic             clock,
   input  logic             reset,
   eno3_req_if.sink         req_chan,
   output eno3_pkg::win_type window,
   output logic             win_valid,
   output logic             win_last,
   input  logic             win_ready
);
   import eno3_pkg::*;

   win_type           window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] fill_base, fill_step;
   logic              win_v_ff, win_v_in;
   logic              win_last_ff, win_last_in;
   logic              accept;

   // A new request enters when the window is empty or is being handed on.
   assign req_chan.ready = !win_v_ff || win_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Shift in the new sample and count how much of the row is present.
   always_comb begin
      fill_base   = req_chan.row_start ? '0 : fill_ff;
      fill_step   = (fill_base < FILL_W'(WIN_LEN)) ? FILL_W'(fill_base + FILL_W'(1))
                                                   : fill_base;
      window_in   = window_ff;
      fill_in     = fill_ff;
      win_last_in = win_last_ff;
      win_v_in    = win_v_ff;
      if (accept) begin
         window_in   = {req_chan.sample, window_ff[WIN_LEN-1:1]};
         fill_in     = req_chan.row_end ? '0 : fill_step;
         win_last_in = req_chan.row_end;
         win_v_in    = (fill_step == FILL_W'(WIN_LEN));
      end else if (win_ready) begin
         win_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         win_v_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         win_v_ff <= win_v_in;
      end
   end

   // Sample storage only matters once a full row window is present.
   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      win_last_ff <= win_last_in;
   end

   assign window    = window_ff;
   assign win_valid = win_v_ff;
   assign win_last  = win_last_ff;

`ifndef NO_ASSERTIONS
   ap_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_LEN))
      else $error("fill count beyond window length");

   ap_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.row_end |=> fill_ff == '0)
      else $error("fill count not cleared after row end");

   ap_valid_needs_full: assert property (@(posedge clock) disable iff (reset)
      win_v_ff && !win_last_ff |-> fill_ff == FILL_W'(WIN_LEN))
      else $error("window handed on without a full row window");
`endif

endmodule

// ----- sv/eno3_select.sv -----
// ENO difference selection stage of the ENO3 advection stencil.
module eno3_select (
   input  logic                        clock,
   input  logic                        reset,
   input  eno3_pkg::win_type           window,
   input  logic                        win_valid,
   input  logic                        win_last,
   output logic                        win_ready,
   input  logic signed [eno3_pkg::CFL_W-1:0] cfl,
   output logic                        sel_valid,
   output eno3_pkg::sel_type           sel,
   input  logic                        sel_ready
);
   import eno3_pkg::*;

   logic signed [D3_W-1:0] ws [WIN_LEN];
   logic signed [D3_W-1:0] d2 [3];
   logic signed [D3_W-1:0] d3 [4];
   logic signed [D3_W-1:0] pick3 [3];
   logic signed [D3_W-1:0] a1, a2, c3, d1;
   logic                   upwind_left, second_left;
   logic                   sel_v_ff, sel_v_in;
   sel_type                sel_ff, sel_in;

   function automatic logic [D3_W-1:0] mag(input logic signed [D3_W-1:0] v);
      return v[D3_W-1] ? D3_W'(-v) : D3_W'(v);
   endfunction

   // Second and third differences at every candidate position.
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         ws[i] = D3_W'(signed'(window[i]));
      end
      for (int j = 0; j < 3; j++) begin
         d2[j] = ws[j+3] - (ws[j+2] <<< 1) + ws[j+1];
      end
      for (int j = 0; j < 4; j++) begin
         d3[j] = ws[j+3] - (ws[j+2] <<< 1) - ws[j+2] + (ws[j+1] <<< 1) + ws[j+1] - ws[j];
      end
      for (int j = 0; j < 3; j++) begin
         pick3[j] = (mag(d3[j]) <= mag(d3[j+1])) ? d3[j] : d3[j+1];
      end
   end

   // Upwind side from the sign of the rate; ties prefer the left stencil.
   always_comb begin
      upwind_left = !cfl[CFL_W-1] && (cfl != '0);
      a1          = upwind_left ? d2[0] : d2[1];
      a2          = upwind_left ? d2[1] : d2[2];
      second_left = (mag(a1) <= mag(a2));
      d1          = upwind_left ? (ws[3] - ws[2]) : (ws[4] - ws[3]);
      case ({upwind_left, second_left})
         2'b11:   c3 = pick3[0];
         2'b10:   c3 = pick3[1];
         2'b01:   c3 = pick3[1];
         default: c3 = pick3[2];
      endcase
      sel_in.d1          = D1_W'(d1);
      sel_in.c2          = D2_W'(second_left ? a1 : a2);
      sel_in.c3          = c3;
      sel_in.upwind_left = upwind_left;
      sel_in.second_left = second_left;
      sel_in.old         = signed'(window[STENCIL_HALF]);
      sel_in.last        = win_last;
   end

   assign win_ready = !sel_v_ff || sel_ready;
   assign sel_v_in  = win_ready ? win_valid : sel_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
      end else begin
         sel_v_ff <= sel_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_ready && win_valid) begin
         sel_ff <= sel_in;
      end
   end

   assign sel_valid = sel_v_ff;
   assign sel       = sel_ff;

endmodule

// ----- sv/eno3_scale.sv -----
// Sum, rate multiply, rounded division by six and saturation pipeline.
module eno3_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sel_valid,
   input  eno3_pkg::sel_type                 sel,
   output logic                              sel_ready,
   input  logic signed [eno3_pkg::CFL_W-1:0] cfl,
   eno3_rsp_if.source                        rsp_chan
);
   import eno3_pkg::*;

   localparam int PLO_W  = 2 * CFL_W;
   localparam int PHI_W  = CFL_W + MAG_W - 32;
   localparam int Y_W    = MAG_W + 3;
   localparam int HALF_W = Y_W / 2;
   localparam int RES_W  = Y_W + 2;
   // Half the divisor, added so that the floor rounds to nearest.
   localparam logic [Y_W-1:0] ROUND_BIAS = Y_W'(3);
   localparam logic signed [RES_W-1:0] RES_MAX = (RES_W'(1) <<< (SAMPLE_W - 1)) - RES_W'(1);
   localparam logic signed [RES_W-1:0] RES_MIN = -(RES_W'(1) <<< (SAMPLE_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] old;
      logic                       last;
      logic                       neg;
   } tag_type;

   // Stage valids and ready chain.
   logic sum_v_ff, mul_v_ff, y_v_ff, hi_v_ff, lo_v_ff, out_v_ff;
   logic sum_rdy, mul_rdy, y_rdy, hi_rdy, lo_rdy, out_rdy;

   // Stage payloads.
   logic signed [S6_W-1:0]     s6_ff, s6_in;
   logic [PLO_W-1:0]           p_lo_ff, p_lo_in;
   logic [PHI_W-1:0]           p_hi_ff, p_hi_in;
   logic [Y_W-1:0]             y_ff, y_in;
   logic [HALF_W-1:0]          qh_ff, qh_in, lo_part_ff;
   logic [2:0]                 rh_ff, rh_in;
   logic [Y_W-1:0]             q_ff, q_in;
   logic signed [SAMPLE_W-1:0] out_value_ff, out_value_in;
   logic                       out_last_ff;
   tag_type                    sum_tag_ff, sum_tag_in, mul_tag_ff, mul_tag_in;
   tag_type                    y_tag_ff, hi_tag_ff, lo_tag_ff;

   // Intermediate terms.
   logic signed [S6_W-1:0]    d1x, c2x, c3x, t1, t2, t3;
   logic [CFL_W-1:0]          cfl_mag;
   logic [S6_W-1:0]           s6_mag;
   logic [DIV6_OUT_W-1:0]     qh_full, qz_full;
   logic [DIV6_IN_W-1:0]      times6, rh_full;
   logic signed [RES_W-1:0]   old_x, q_x, res;

   // A stage loads when it is empty or its content moves on.
   assign out_rdy   = !out_v_ff || rsp_chan.ready;
   assign lo_rdy    = !lo_v_ff || out_rdy;
   assign hi_rdy    = !hi_v_ff || lo_rdy;
   assign y_rdy     = !y_v_ff || hi_rdy;
   assign mul_rdy   = !mul_v_ff || y_rdy;
   assign sum_rdy   = !sum_v_ff || mul_rdy;
   assign sel_ready = sum_rdy;

   // Six times the ENO flux difference, with the third-order coefficient folded in.
   always_comb begin
      d1x = S6_W'(signed'(sel.d1));
      c2x = S6_W'(signed'(sel.c2));
      c3x = S6_W'(signed'(sel.c3));
      t1  = (d1x <<< 2) + (d1x <<< 1);
      t2  = sel.upwind_left ? ((c2x <<< 1) + c2x) : -((c2x <<< 1) + c2x);
      t3  = (sel.upwind_left ^ sel.second_left) ? -(c3x <<< 1) : (c3x <<< 2);
      s6_in           = t1 + t2 + t3;
      sum_tag_in.old  = sel.old;
      sum_tag_in.last = sel.last;
      sum_tag_in.neg  = 1'b0;
   end

   // Magnitude product of rate and sum, split into two partial products.
   always_comb begin
      cfl_mag = cfl[CFL_W-1] ? CFL_W'(-cfl) : CFL_W'(cfl);
      s6_mag  = s6_ff[S6_W-1] ? S6_W'(-s6_ff) : S6_W'(s6_ff);
      p_lo_in = PLO_W'(cfl_mag) * PLO_W'(s6_mag[31:0]);
      p_hi_in = PHI_W'(cfl_mag) * PHI_W'(s6_mag[MAG_W-1:32]);
      mul_tag_in     = sum_tag_ff;
      mul_tag_in.neg = cfl[CFL_W-1] ^ s6_ff[S6_W-1];
   end

   // Drop the Q1.30 fraction and add the rounding bias.
   assign y_in = Y_W'({p_hi_ff, 2'b00}) + Y_W'(p_lo_ff[PLO_W-1:30]) + ROUND_BIAS;

   // Long division by six in two halves: upper half first.
   always_comb begin
      qh_full = div6(DIV6_IN_W'(y_ff[Y_W-1:HALF_W]));
      qh_in   = qh_full[HALF_W-1:0];
      times6  = DIV6_IN_W'({qh_in, 2'b00}) + DIV6_IN_W'({qh_in, 1'b0});
      rh_full = DIV6_IN_W'(y_ff[Y_W-1:HALF_W]) - times6;
      rh_in   = rh_full[2:0];
   end

   // Lower half takes the remainder of the upper one.
   always_comb begin
      qz_full = div6({rh_ff, lo_part_ff});
      q_in    = {qh_ff, qz_full[HALF_W-1:0]};
   end

   // Apply the correction and saturate to the sample range.
   always_comb begin
      old_x = RES_W'(signed'(lo_tag_ff.old));
      q_x   = signed'(RES_W'(q_ff));
      res   = lo_tag_ff.neg ? (old_x + q_x) : (old_x - q_x);
      if (res > RES_MAX) begin
         out_value_in = RES_MAX[SAMPLE_W-1:0];
      end else if (res < RES_MIN) begin
         out_value_in = RES_MIN[SAMPLE_W-1:0];
      end else begin
         out_value_in = res[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         y_v_ff   <= 1'b0;
         hi_v_ff  <= 1'b0;
         lo_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (sum_rdy) sum_v_ff <= sel_valid;
         if (mul_rdy) mul_v_ff <= sum_v_ff;
         if (y_rdy)   y_v_ff   <= mul_v_ff;
         if (hi_rdy)  hi_v_ff  <= y_v_ff;
         if (lo_rdy)  lo_v_ff  <= hi_v_ff;
         if (out_rdy) out_v_ff <= lo_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_rdy && sel_valid) begin
         s6_ff      <= s6_in;
         sum_tag_ff <= sum_tag_in;
      end
      if (mul_rdy && sum_v_ff) begin
         p_lo_ff    <= p_lo_in;
         p_hi_ff    <= p_hi_in;
         mul_tag_ff <= mul_tag_in;
      end
      if (y_rdy && mul_v_ff) begin
         y_ff     <= y_in;
         y_tag_ff <= mul_tag_ff;
      end
      if (hi_rdy && y_v_ff) begin
         qh_ff      <= qh_in;
         rh_ff      <= rh_in;
         lo_part_ff <= y_ff[HALF_W-1:0];
         hi_tag_ff  <= y_tag_ff;
      end
      if (lo_rdy && hi_v_ff) begin
         q_ff      <= q_in;
         lo_tag_ff <= hi_tag_ff;
      end
      if (out_rdy && lo_v_ff) begin
         out_value_ff <= out_value_in;
         out_last_ff  <= lo_tag_ff.last;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.new_value   = out_value_ff;
   assign rsp_chan.last_of_row = out_last_ff;

`ifndef NO_ASSERTIONS
   ap_remainder_range: assert property (@(posedge clock) disable iff (reset)
      hi_v_ff |-> rh_ff < 3'd6)
      else $error("upper remainder of division by six out of range");

   ap_bias_present: assert property (@(posedge clock) disable iff (reset)
      y_v_ff |-> y_ff >= ROUND_BIAS)
      else $error("rounded product lost its bias");
`endif

endmodule

// ----- sv/eno3_advection_stencil.sv -----
// Top level of the ENO3 upwind advection stencil with its register port.
//
// Requests on req_chan carry one Q16.16 sample of a row per beat, with
// row_start and row_end marking the ends of the row. Once seven samples of
// a row are in, every request yields one result on rsp_chan: the updated
// value of the cell three behind it, saturated, with last_of_row set on the
// result of the request that carried row_end. The three cells at each end
// of a row and rows shorter than seven give no result.
// The rate register cfl (Q1.30, address 0) is written over the csr_ port;
// the user must write it only while no request is in flight, which the
// block does not enforce. Its sign selects the upwind side. A result
// passes the window, selection, sum, rate multiply, bias add and two
// halves of the division by six, then the output register. One request is
// accepted every cycle unless rsp_chan stalls; each of the eight stages
// holds one request and moves on in the cycle its successor frees up.
// Reset clears the row fill count, all stage valids and cfl.
// When rsp_chan stalls, stages fill up behind the output register and
// req_chan.ready falls only once every stage holds a request.
module eno3_advection_stencil (
   input  logic                                clock,
   input  logic                                reset,
   eno3_req_if.sink                            req_chan,
   eno3_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [eno3_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [eno3_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [eno3_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import eno3_pkg::*;

   logic signed [CFL_W-1:0] cfl_ff, cfl_in;
   logic [CSR_IDX_W-1:0]    csr_idx;
   logic                    csr_write;
   win_type                 window;
   logic                    win_valid, win_last, win_ready;
   logic                    sel_valid, sel_ready;
   sel_type                 sel;

   // Register port: single rate register, zero wait states.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfl_in     = (csr_write && (csr_idx == CSR_CFL)) ? signed'(CFL_W'(csr_pwdata))
                                                           : cfl_ff;
   assign csr_prdata = (csr_idx == CSR_CFL) ? CSR_DATA_W'(cfl_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfl_ff <= '0;
      end else begin
         cfl_ff <= cfl_in;
      end
   end

   eno3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .window    (window),
      .win_valid (win_valid),
      .win_last  (win_last),
      .win_ready (win_ready)
   );

   eno3_select u_select (
      .clock     (clock),
      .reset     (reset),
      .window    (window),
      .win_valid (win_valid),
      .win_last  (win_last),
      .win_ready (win_ready),
      .cfl       (cfl_ff),
      .sel_valid (sel_valid),
      .sel       (sel),
      .sel_ready (sel_ready)
   );

   eno3_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .sel_valid (sel_valid),
      .sel       (sel),
      .sel_ready (sel_ready),
      .cfl       (cfl_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- sim/eno3_advection_scoreboard.sv -----
// Scoreboard of the ENO3 advection stencil: predicts every updated cell and checks the results.
module eno3_advection_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   eno3_req_if                             req_mon,
   eno3_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [eno3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [eno3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import eno3_pkg::*;

   // One predicted result: the updated centre cell and its end-of-row flag.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] new_value;
      logic                       last_of_row;
   } cell_update_type;

   // Shadow of the block: sample window, row fill count and the rate register.
   logic signed [SAMPLE_W-1:0] row_win [WIN_LEN];
   int                         fill;
   logic signed [CFL_W-1:0]    cfl_reg;
   cell_update_type            expected_cells [$];
   int                         mismatches;

   // Sample at an offset of -3..3 from the centre cell, sign extended.
   function automatic longint tap(input int offset);
      return longint'(row_win[STENCIL_HALF + offset]);
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint second_diff(input int c);
      return tap(c + 1) - 2 * tap(c) + tap(c - 1);
   endfunction

   function automatic longint third_diff(input int m);
      return tap(m + 2) - 3 * tap(m + 1) + 3 * tap(m) - tap(m - 1);
   endfunction

   // Third-order ENO upwind update of the centre cell, rounded and saturated.
   function automatic logic signed [SAMPLE_W-1:0] advect_centre();
      longint       rate, sec_l, sec_r, sec_pick, thr_l, thr_r, thr_pick;
      longint       up_diff, s6, coef, old, updated;
      int           k, d, e, k3;
      bit           take_left, flip;
      logic [127:0] prod, quot, remd;

      rate = longint'(cfl_reg);
      // A positive rate takes its upwind values from the left.
      k = (rate > 0) ? -1 : 0;
      d = -k;

      // Smoother second difference; equal magnitudes favor the left one.
      sec_l = second_diff(k);
      sec_r = second_diff(k + 1);
      take_left = magnitude(sec_l) <= magnitude(sec_r);
      sec_pick = take_left ? sec_l : sec_r;
      k3 = take_left ? k - 1 : k;
      e = take_left ? d + 1 : d;
      coef = 3 * e * e - 6 * e + 2;

      // Smoother third difference on the side the second difference chose.
      thr_l = third_diff(k3);
      thr_r = third_diff(k3 + 1);
      thr_pick = (magnitude(thr_l) <= magnitude(thr_r)) ? thr_l : thr_r;

      // Six times the flux sum in sample units.
      up_diff = tap(k + 1) - tap(k);
      s6 = 6 * up_diff + 3 * (2 * d - 1) * sec_pick + 2 * coef * thr_pick;

      // Exact cfl * s6 / (6 * 2^30), magnitude rounded half away from zero.
      prod = {64'd0, magnitude(rate)} * {64'd0, magnitude(s6)};
      quot = prod / (128'd6 << 30);
      remd = prod % (128'd6 << 30);
      if (remd >= (128'd3 << 30)) begin
         quot = quot + 1;
      end
      flip = (rate < 0) != (s6 < 0);

      old = tap(0);
      updated = flip ? old + longint'(quot[63:0]) : old - longint'(quot[63:0]);
      if (updated > 64'sd2147483647) begin
         updated = 64'sd2147483647;
      end
      if (updated < -64'sd2147483648) begin
         updated = -64'sd2147483648;
      end
      return updated[SAMPLE_W-1:0];
   endfunction

   // Track register writes and requests, and compare every result in order.
   always @(posedge clock) begin : watch
      cell_update_type want;
      if (reset) begin
         for (int j = 0; j < WIN_LEN; j++) begin
            row_win[j] = '0;
         end
         fill = 0;
         cfl_reg = '0;
         expected_cells.delete();
         mismatches = 0;
         fail_count <= 0;
         pending_results <= 0;
      end else begin
         // Rate register write in the access phase.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_CFL) begin
            cfl_reg = csr_pwdata;
         end

         // Accepted request: shift the window and predict the centre cell.
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.row_start) begin
               fill = 0;
            end
            for (int j = 0; j < WIN_LEN - 1; j++) begin
               row_win[j] = row_win[j + 1];
            end
            row_win[WIN_LEN-1] = req_mon.sample;
            if (fill < WIN_LEN) begin
               fill++;
            end
            if (fill >= WIN_LEN) begin
               want.new_value = advect_centre();
               want.last_of_row = req_mon.row_end;
               expected_cells.push_back(want);
            end
            if (req_mon.row_end) begin
               fill = 0;
            end
         end

         // Accepted result: compare with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cells.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected result: new_value %h last_of_row %b",
                           rsp_mon.new_value, rsp_mon.last_of_row);
               end
            end else begin
               want = expected_cells.pop_front();
               if (rsp_mon.new_value !== want.new_value ||
                   rsp_mon.last_of_row !== want.last_of_row) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected new_value %h last_of_row %b, got %h %b",
                              want.new_value, want.last_of_row,
                              rsp_mon.new_value, rsp_mon.last_of_row);
                  end
               end
            end
         end

         pending_results <= expected_cells.size();
         fail_count <= mismatches;
      end
   end

endmodule

// ----- sim/tb_eno3_advection_stencil.sv -----
// Testbench top of the ENO3 advection stencil: clock, reset, requests, rate writes and verdict.
module tb_eno3_advection_stencil;
   timeunit 1ns;
   timeprecision 1ps;
   import eno3_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 175;

   // Kinds of row content.
   typedef enum int {FILL_RANDOM, FILL_SMALL, FILL_EXTREME, FILL_RAMP} fill_style_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending_results;
   int                    send_idle_pct;
   int                    stall_pct;
   int                    cycle_count = 0;

   eno3_req_if req_bus ();
   eno3_rsp_if rsp_bus ();

   eno3_advection_stencil dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   eno3_advection_scoreboard scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
   end

   // Give up on a hung run.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Offer one request after a random idle gap and hold it until accepted.
   task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic first,
                              input logic last);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 20) begin
         gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= value;
      req_bus.row_start <= first;
      req_bus.row_end <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Write the rate register: setup cycle, then access cycle.
   task automatic write_cfl(input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_CFL, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Stop sending, wait for every predicted result, then let the pipeline settle.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One row of samples; a malformed row gets random start and end marks.
   task automatic send_row(input int len, input fill_style_type style, input bit well_formed);
      logic [SAMPLE_W-1:0] value;
      logic [SAMPLE_W-1:0] ramp;
      int                  slope;
      ramp = $urandom;
      slope = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      for (int i = 0; i < len; i++) begin
         case (style)
            FILL_RANDOM: value = $urandom;
            FILL_SMALL: value = 32'(int'($urandom_range(0, 8)) - 4) << 16;
            FILL_EXTREME: begin
               case ($urandom_range(0, 3))
                  0: value = 32'h7FFF_FFFF;
                  1: value = 32'h8000_0000;
                  2: value = 32'h0000_0000;
                  default: value = 32'hFFFF_FFFF;
               endcase
            end
            default: begin
               ramp = ramp + 32'(slope) + $urandom_range(0, 15);
               value = ramp;
            end
         endcase
         if (well_formed) begin
            push_sample(value, i == 0, i == len - 1);
         end else begin
            push_sample(value, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
         end
      end
   endtask

   initial begin : stimulus
      int                  p;
      int                  sent;
      int                  len;
      int                  pick;
      logic [CSR_DATA_W-1:0] rate;

      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      req_bus.row_start <= 1'b0;
      req_bus.row_end <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      send_idle_pct = 0;
      stall_pct <= 0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero rate after reset: the centre cell passes through unchanged.
      for (int i = 0; i < 7; i++) begin
         push_sample((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 0, i == 6);
      end
      drain_results();

      // Full positive rate on alternating extremes drives the output into saturation.
      write_cfl(32'h4000_0000);
      for (int i = 0; i < 8; i++) begin
         push_sample((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 0, i == 7);
      end

      // A row too short to give any result.
      for (int i = 0; i < 3; i++) begin
         push_sample($urandom, i == 0, i == 2);
      end

      // Samples after a row end without a start mark, then a restart on a flat row,
      // where every pair of differences ties.
      for (int i = 0; i < 9; i++) begin
         push_sample((i < 2) ? $urandom : 32'h0001_0000, i == 2, i == 8);
      end
      drain_results();

      // Random phases, each with its own rate and one of four idling patterns.
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: rate = 32'h4000_0000;
            1: rate = 32'hC000_0000;
            2: rate = '0;
            3: rate = $urandom_range(1, 32'h4000_0000);
            4: rate = -$urandom_range(1, 32'h4000_0000);
            5: rate = 32'h7FFF_FFFF;
            6: rate = 32'h8000_0000;
            default: rate = $urandom;
         endcase
         write_cfl(rate);
         send_idle_pct = (p % 4 == 1) ? 68 : (p % 4 == 3) ? 30 : 0;
         stall_pct <= (p % 4 == 2) ? 68 : (p % 4 == 3) ? 30 : 0;

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                 : $urandom_range(7, 24);
               send_row(len, fill_style_type'($urandom_range(0, 3)), 1'b1);
            end else if (pick < 90) begin
               len = $urandom_range(1, 6);
               send_row(len, fill_style_type'($urandom_range(0, 3)), 1'b1);
            end else begin
               len = $urandom_range(1, 20);
               send_row(len, fill_style_type'($urandom_range(0, 3)), 1'b0);
            end
            sent += len;
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
